### src/mb3_pkg.sv
// types, constants and saturation helpers for the mandelbulb iteration step core
// no dependencies; used by mb3_plane and mandelbulb3_iteration_step_core
`timescale 1ns / 1ps

package mb3_pkg;

  localparam int DATA_W   = 32;
  localparam int UDATA_W  = 31;
  localparam int ROOT_W   = 32;
  localparam int SQ_W     = 2 * DATA_W;
  localparam int REM_W    = ROOT_W + 3;
  // abs, products, sum, then root and division stages
  localparam int PLANE_LAT = 3 + 2 * ROOT_W;
  localparam int TOTAL_LAT = 2 * PLANE_LAT + 4;
  localparam logic [39:0] POS_LIMIT = 40'h007FFFFFFF;
  localparam logic [39:0] NEG_LIMIT = 40'h0080000000;

  typedef struct packed {
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;
    logic [30:0]        radius_in;
    logic [30:0]        dist_est_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
    logic [30:0]        dist_est_out;
    logic               degenerate;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic        nz;
    logic [31:0] p_mag;
    logic        p_neg;
    logic [31:0] q_mag;
    logic        q_neg;
  } plane_res_t;

  typedef struct packed {
    logic signed [31:0] z;
    logic [30:0]        rad;
    logic [30:0]        de;
    logic               neg0;
  } side1_t;

  typedef struct packed {
    logic signed [31:0] y1;
    logic [30:0]        rad;
    logic [30:0]        de;
    logic               neg0;
    logic               x1_neg;
    logic               clip;
    logic               degen;
  } side2_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               clip;
  } sat_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] u;
    u = v;
    return v[31] ? (~u + 32'd1) : u;
  endfunction

  // sign a magnitude and clip to signed 32 bit
  function automatic sat_t sat_s32(input logic [39:0] mag, input logic neg);
    sat_t s;
    logic [39:0] n;
    n = 40'd0 - mag;
    if (neg) begin
      if (mag > NEG_LIMIT) begin
        s.val  = 32'sh80000000;
        s.clip = 1'b1;
      end else begin
        s.val  = n[31:0];
        s.clip = 1'b0;
      end
    end else begin
      if (mag > POS_LIMIT) begin
        s.val  = 32'sh7FFFFFFF;
        s.clip = 1'b1;
      end else begin
        s.val  = mag[31:0];
        s.clip = 1'b0;
      end
    end
    return s;
  endfunction

endpackage

### src/mandelbulb3_iteration_step_core.sv
// top level of the power-two mandelbulb iteration step, signed Q8.24
// depends on mb3_pkg and mb3_plane
`timescale 1ns / 1ps
//
//  channel   ports                      handshake
//  request   start, busy, in_item       taken when start is high and busy low
//  result    out_valid, out_item        one-cycle strobe, cannot be held off
//
//  one request can enter every cycle; busy is always low
//  each request passes the two 32-step root and 32-step division chains
//  of each plane unit plus the saturation and radius scaling stages
//  synchronous reset clears every valid bit; requests in flight are dropped
//  no stall exists: every stage moves each cycle

module mandelbulb3_iteration_step_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mb3_pkg::in_item_t   in_item,
  output logic                out_valid,
  output mb3_pkg::out_item_t  out_item
);

  localparam int S1W = $bits(mb3_pkg::side1_t);
  localparam int S2W = $bits(mb3_pkg::side2_t);

  logic take;
  assign busy = 1'b0;
  assign take = start && !busy;

  // first plane: xy
  mb3_pkg::side1_t    sd1_in, sd1_out;
  mb3_pkg::plane_res_t r1;
  logic [S1W-1:0]     sd1_out_v;

  always_comb begin
    sd1_in.z    = in_item.z_in;
    sd1_in.rad  = in_item.radius_in;
    sd1_in.de   = in_item.dist_est_in;
    sd1_in.neg0 = in_item.x_in[31];
  end

  mb3_plane #(.SIDE_W(S1W)) u_plane_xy (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (take),
    .a        (in_item.x_in),
    .b        (in_item.y_in),
    .in_side  (sd1_in),
    .res      (r1),
    .res_side (sd1_out_v)
  );
  assign sd1_out = sd1_out_v;

  // clip x1, y1 before the xz plane
  mb3_pkg::sat_t      sx1_nxt, sy1_nxt;
  logic               v1_r;
  mb3_pkg::side2_t    sd2_r;
  logic signed [31:0] x1_r, z1_r;

  always_comb begin
    sx1_nxt = mb3_pkg::sat_s32({8'd0, r1.p_mag}, r1.p_neg);
    sy1_nxt = mb3_pkg::sat_s32({8'd0, r1.q_mag}, r1.q_neg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= r1.valid;
  end

  always_ff @(posedge clk) begin
    x1_r         <= sx1_nxt.val;
    z1_r         <= sd1_out.z;
    sd2_r.y1     <= sy1_nxt.val;
    sd2_r.rad    <= sd1_out.rad;
    sd2_r.de     <= sd1_out.de;
    sd2_r.neg0   <= sd1_out.neg0;
    sd2_r.x1_neg <= sx1_nxt.val[31];
    sd2_r.clip   <= sx1_nxt.clip | sy1_nxt.clip;
    sd2_r.degen  <= !r1.nz;
  end

  // second plane: xz
  mb3_pkg::plane_res_t r2;
  mb3_pkg::side2_t     sd2_out;
  logic [S2W-1:0]      sd2_out_v;

  mb3_plane #(.SIDE_W(S2W)) u_plane_xz (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v1_r),
    .a        (x1_r),
    .b        (z1_r),
    .in_side  (sd2_r),
    .res      (r2),
    .res_side (sd2_out_v)
  );
  assign sd2_out = sd2_out_v;

  // sign corrections from x1 and x_in, clip
  mb3_pkg::sat_t      sx2_nxt, sz2_nxt;
  logic               v2_r, clip2_r, deg2_r;
  logic signed [31:0] x2_r, y2_r, z2_r;
  logic [30:0]        rad2_r, de2_r;

  always_comb begin
    sx2_nxt = mb3_pkg::sat_s32({8'd0, r2.p_mag}, r2.p_neg ^ sd2_out.x1_neg);
    sz2_nxt = mb3_pkg::sat_s32({8'd0, r2.q_mag}, r2.q_neg ^ sd2_out.neg0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= r2.valid;
  end

  always_ff @(posedge clk) begin
    x2_r    <= sx2_nxt.val;
    y2_r    <= sd2_out.y1;
    z2_r    <= sz2_nxt.val;
    rad2_r  <= sd2_out.rad;
    de2_r   <= sd2_out.de;
    clip2_r <= sd2_out.clip | sx2_nxt.clip | sz2_nxt.clip;
    deg2_r  <= sd2_out.degen | !r2.nz;
  end

  // radius scaling products
  logic        v3_r, clip3_r, deg3_r, xn3_r, yn3_r, zn3_r;
  logic [62:0] mx3_r, my3_r, mz3_r;
  logic [61:0] mde3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    mx3_r   <= 63'(mb3_pkg::mag32(x2_r)) * 63'(rad2_r);
    my3_r   <= 63'(mb3_pkg::mag32(y2_r)) * 63'(rad2_r);
    mz3_r   <= 63'(mb3_pkg::mag32(z2_r)) * 63'(rad2_r);
    mde3_r  <= 62'(de2_r) * 62'(rad2_r);
    xn3_r   <= x2_r[31];
    yn3_r   <= y2_r[31];
    zn3_r   <= z2_r[31];
    clip3_r <= clip2_r;
    deg3_r  <= deg2_r;
  end

  // shift back to Q8.24, clip, output register
  mb3_pkg::sat_t      sx_nxt, sy_nxt, sz_nxt;
  logic [38:0]        dm;
  logic               dm_clip;
  logic               out_valid_r;
  mb3_pkg::out_item_t out_r;

  always_comb begin
    sx_nxt  = mb3_pkg::sat_s32({1'b0, mx3_r[62:24]}, xn3_r);
    sy_nxt  = mb3_pkg::sat_s32({1'b0, my3_r[62:24]}, yn3_r);
    sz_nxt  = mb3_pkg::sat_s32({1'b0, mz3_r[62:24]}, zn3_r);
    dm      = mde3_r[61:23];
    dm_clip = dm > 39'h007FFFFFFF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    out_r.x_out        <= sx_nxt.val;
    out_r.y_out        <= sy_nxt.val;
    out_r.z_out        <= sz_nxt.val;
    out_r.dist_est_out <= dm_clip ? 31'h7FFFFFFF : dm[30:0];
    out_r.degenerate   <= deg3_r;
    out_r.saturated    <= clip3_r | sx_nxt.clip | sy_nxt.clip | sz_nxt.clip | dm_clip;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // every result comes from a request taken a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(take, mb3_pkg::TOTAL_LAT))
    else $error("result without matching request");

  // a zero xy length leaves x1 and y1 at zero
  a_degen_xy: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && sd2_r.degen) |-> (x1_r == 32'sd0 && sd2_r.y1 == 32'sd0))
    else $error("xy plane not zeroed on zero length");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // zero radius scales the point to the origin
  a_rad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && rad2_r == 31'd0) |=>
      (mx3_r == 63'd0 && my3_r == 63'd0 && mz3_r == 63'd0))
    else $error("zero radius did not clear the point");

endmodule

### src/mb3_plane.sv
// one plane squaring: (a,b) -> ((a^2-b^2)/len, 2ab/len), len = floor sqrt(a^2+b^2)
// pipelined root and restoring division, one bit a stage; uses mb3_pkg
`timescale 1ns / 1ps

module mb3_plane #(
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic signed [31:0]       a,
  input  logic signed [31:0]       b,
  input  logic [SIDE_W-1:0]        in_side,
  output mb3_pkg::plane_res_t      res,
  output logic [SIDE_W-1:0]        res_side
);

  localparam int N  = mb3_pkg::ROOT_W;
  localparam int SW = mb3_pkg::SQ_W;
  localparam int RW = mb3_pkg::REM_W;
  localparam int LAST = 2 * N;

  // magnitude stage
  logic              va_r, qna_r;
  logic [31:0]       ma_r, mb_r;
  logic [SIDE_W-1:0] sda_r;
  // product stage
  logic              vb_r, qnb_r;
  logic [SW-1:0]     a2_r, b2_r, ab_r;
  logic [SIDE_W-1:0] sdb_r;

  // line of stages, index 0 is the sum stage
  logic              vld_r  [0:LAST];
  logic              pn_r   [0:LAST];
  logic              qn_r   [0:LAST];
  logic [SIDE_W-1:0] side_r [0:LAST];
  logic [SW-1:0]     dp_r   [0:LAST];
  logic [SW-1:0]     dq_r   [0:LAST];
  logic [SW-1:0]     sum_r  [0:N];
  logic [RW-1:0]     srem_r [1:N];
  logic [N-1:0]      root_r [1:LAST];
  logic [31:0]       prem_r [N+1:LAST];
  logic [31:0]       pquo_r [N+1:LAST];
  logic [31:0]       qrem_r [N+1:LAST];
  logic [31:0]       qquo_r [N+1:LAST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r     <= 1'b0;
      vb_r     <= 1'b0;
      vld_r[0] <= 1'b0;
    end else begin
      va_r     <= in_valid;
      vb_r     <= va_r;
      vld_r[0] <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    ma_r  <= mb3_pkg::mag32(a);
    mb_r  <= mb3_pkg::mag32(b);
    qna_r <= a[31] ^ b[31];
    sda_r <= in_side;
    a2_r  <= SW'(ma_r) * SW'(ma_r);
    b2_r  <= SW'(mb_r) * SW'(mb_r);
    ab_r  <= SW'(ma_r) * SW'(mb_r);
    qnb_r <= qna_r;
    sdb_r <= sda_r;
    sum_r[0]  <= a2_r + b2_r;
    dp_r[0]   <= (a2_r >= b2_r) ? (a2_r - b2_r) : (b2_r - a2_r);
    pn_r[0]   <= a2_r < b2_r;
    dq_r[0]   <= {ab_r[SW-2:0], 1'b0};
    qn_r[0]   <= qnb_r;
    side_r[0] <= sdb_r;
  end

  // integer square root, two radicand bits a stage
  for (genvar i = 0; i < N; i++) begin : g_root
    logic [RW-1:0] rem_in, cat, trial;
    logic [N-1:0]  root_in;
    logic          take;
    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = srem_r[i];
      assign root_in = root_r[i];
    end
    always_comb begin
      cat   = {rem_in[RW-3:0], sum_r[i][SW-1-2*i -: 2]};
      trial = {1'b0, root_in, 2'b01};
      take  = cat >= trial;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i+1] <= 1'b0;
      else        vld_r[i+1] <= vld_r[i];
    end
    always_ff @(posedge clk) begin
      srem_r[i+1] <= take ? (cat - trial) : cat;
      root_r[i+1] <= {root_in[N-2:0], take};
      if (i + 1 < N) sum_r[i+1] <= sum_r[i];
      dp_r[i+1]   <= dp_r[i];
      dq_r[i+1]   <= dq_r[i];
      pn_r[i+1]   <= pn_r[i];
      qn_r[i+1]   <= qn_r[i];
      side_r[i+1] <= side_r[i];
    end
  end

  // two restoring dividers by the root, one quotient bit a stage
  for (genvar j = 0; j < N; j++) begin : g_div
    localparam int T = N + j;
    logic [31:0] pr_in, pq_in, qr_in, qq_in;
    logic [32:0] pcat, qcat, dv;
    logic        pge, qge;
    if (j == 0) begin : g_first
      assign pr_in = dp_r[N][SW-1:32];
      assign qr_in = dq_r[N][SW-1:32];
      assign pq_in = '0;
      assign qq_in = '0;
    end else begin : g_next
      assign pr_in = prem_r[T];
      assign qr_in = qrem_r[T];
      assign pq_in = pquo_r[T];
      assign qq_in = qquo_r[T];
    end
    always_comb begin
      dv   = {1'b0, root_r[T]};
      pcat = {pr_in, dp_r[T][31-j]};
      qcat = {qr_in, dq_r[T][31-j]};
      pge  = pcat >= dv;
      qge  = qcat >= dv;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[T+1] <= 1'b0;
      else        vld_r[T+1] <= vld_r[T];
    end
    always_ff @(posedge clk) begin
      prem_r[T+1] <= pge ? 32'(pcat - dv) : pcat[31:0];
      qrem_r[T+1] <= qge ? 32'(qcat - dv) : qcat[31:0];
      pquo_r[T+1] <= {pq_in[30:0], pge};
      qquo_r[T+1] <= {qq_in[30:0], qge};
      root_r[T+1] <= root_r[T];
      dp_r[T+1]   <= dp_r[T];
      dq_r[T+1]   <= dq_r[T];
      pn_r[T+1]   <= pn_r[T];
      qn_r[T+1]   <= qn_r[T];
      side_r[T+1] <= side_r[T];
    end
  end

  logic nz;
  assign nz = root_r[LAST] != '0;

  always_comb begin
    res.valid = vld_r[LAST];
    res.nz    = nz;
    res.p_mag = nz ? pquo_r[LAST] : 32'd0;
    res.p_neg = pn_r[LAST];
    res.q_mag = nz ? qquo_r[LAST] : 32'd0;
    res.q_neg = qn_r[LAST];
  end
  assign res_side = side_r[LAST];

endmodule

### tb/sv/mandelbulb3_iteration_step_core_tb.sv
// self-checking testbench for the power-two mandelbulb iteration step core
// depends on mb3_pkg and mandelbulb3_iteration_step_core; checks every result against a predictor
`timescale 1ns / 1ps

module mandelbulb3_iteration_step_core_tb;

  localparam int N_RANDOM   = 1730;
  localparam int CALM_TAIL  = 200;   // last requests go in without gaps
  localparam int STALL_LIMIT = 5000;
  localparam logic signed [31:0] ONE = 32'sh01000000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  mb3_pkg::in_item_t   in_item = '0;
  logic                out_valid;
  mb3_pkg::out_item_t  out_item;

  mb3_pkg::out_item_t  pending_q[$];
  int         n_errors = 0;
  int         idle_cycles = 0;

  mandelbulb3_iteration_step_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint clip32(longint v, inout bit clipped);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // complex square of (a, b) over its length; returns 0 on zero length
  function automatic bit square_in_plane(longint a, longint b, output longint p,
                                         output longint q);
    longint unsigned ma, mb, a2, b2, len, m;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    a2 = ma * ma;
    b2 = mb * mb;
    len = floor_root(a2 + b2);
    p = 0;
    q = 0;
    if (len == 0) return 1'b0;
    if (a2 >= b2) p = longint'((a2 - b2) / len);
    else          p = -longint'((b2 - a2) / len);
    m = (2 * ma * mb) / len;
    q = ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    return 1'b1;
  endfunction

  function automatic longint radius_scale(longint v, longint unsigned r, inout bit clipped);
    longint unsigned m;
    m = (unsigned'((v < 0) ? -v : v) * r) >> 24;
    return clip32((v < 0) ? -longint'(m) : longint'(m), clipped);
  endfunction

  function automatic mb3_pkg::out_item_t bulb_step(mb3_pkg::in_item_t it);
    mb3_pkg::out_item_t res;
    longint x, y, z, x1, y1, t, x2, z2;
    longint unsigned r, de, dm;
    bit clipped, degen;
    x = it.x_in;
    y = it.y_in;
    z = it.z_in;
    r = it.radius_in;
    de = it.dist_est_in;
    clipped = 1'b0;
    degen = 1'b0;
    dm = (de * r) >> 23;
    if (dm > 64'h7FFFFFFF) begin
      dm = 64'h7FFFFFFF;
      clipped = 1'b1;
    end
    if (!square_in_plane(x, y, x1, y1)) degen = 1'b1;
    x1 = clip32(x1, clipped);
    y1 = clip32(y1, clipped);
    if (!square_in_plane(x1, z, t, z2)) degen = 1'b1;
    x2 = (x1 < 0) ? -t : t;
    if (x < 0) z2 = -z2;
    x2 = clip32(x2, clipped);
    z2 = clip32(z2, clipped);
    res.x_out = 32'(radius_scale(x2, r, clipped));
    res.y_out = 32'(radius_scale(y1, r, clipped));
    res.z_out = 32'(radius_scale(z2, r, clipped));
    res.dist_est_out = dm[30:0];
    res.degenerate = degen;
    res.saturated = clipped;
    return res;
  endfunction

  // ---------------------------------------------------------------- checking

  // every accepted request queues its predicted result
  always @(posedge clk) begin
    if (rst_n && start && !busy) pending_q.push_back(bulb_step(in_item));
  end

  always @(posedge clk) begin
    mb3_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $error("result with nothing pending: %p", out_item);
        n_errors++;
      end else begin
        want = pending_q.pop_front();
        if (out_item.x_out !== want.x_out) begin
          $error("x_out expected %h got %h", want.x_out, out_item.x_out);
          n_errors++;
        end
        if (out_item.y_out !== want.y_out) begin
          $error("y_out expected %h got %h", want.y_out, out_item.y_out);
          n_errors++;
        end
        if (out_item.z_out !== want.z_out) begin
          $error("z_out expected %h got %h", want.z_out, out_item.z_out);
          n_errors++;
        end
        if (out_item.dist_est_out !== want.dist_est_out) begin
          $error("dist_est_out expected %h got %h", want.dist_est_out,
                 out_item.dist_est_out);
          n_errors++;
        end
        if (out_item.degenerate !== want.degenerate) begin
          $error("degenerate expected %b got %b", want.degenerate, out_item.degenerate);
          n_errors++;
        end
        if (out_item.saturated !== want.saturated) begin
          $error("saturated expected %b got %b", want.saturated, out_item.saturated);
          n_errors++;
        end
      end
    end
  end

  // watchdog: cycles in which neither side moves anything
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  typedef struct {
    mb3_pkg::in_item_t  stim;
    bit                 known;
    mb3_pkg::out_item_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic mb3_pkg::in_item_t mk(logic signed [31:0] x, logic signed [31:0] y,
                                           logic signed [31:0] z, logic [30:0] r,
                                           logic [30:0] de);
    mb3_pkg::in_item_t it;
    it.x_in = x;
    it.y_in = y;
    it.z_in = z;
    it.radius_in = r;
    it.dist_est_in = de;
    return it;
  endfunction

  function automatic mb3_pkg::out_item_t mko(logic signed [31:0] x, logic signed [31:0] y,
                                             logic signed [31:0] z, logic [30:0] de,
                                             logic dg, logic st);
    mb3_pkg::out_item_t o;
    o.x_out = x;
    o.y_out = y;
    o.z_out = z;
    o.dist_est_out = de;
    o.degenerate = dg;
    o.saturated = st;
    return o;
  endfunction

  task automatic add_row(mb3_pkg::in_item_t it, bit known = 1'b0,
                         mb3_pkg::out_item_t want = '0);
    dir_row_t row;
    row.stim = it;
    row.known = known;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  function automatic logic signed [31:0] near_unit();
    // values within about +-4.0
    return $signed($urandom_range(0, 32'h08000000)) - 32'sh04000000;
  endfunction

  function automatic mb3_pkg::in_item_t random_request();
    mb3_pkg::in_item_t it;
    int kind;
    kind = $urandom_range(0, 9);
    it = mk(near_unit(), near_unit(), near_unit(), 31'($urandom_range(0, 32'h04000000)),
            31'($urandom_range(0, 32'h08000000)));
    case (kind)
      0, 1: begin
        it = mk($urandom, $urandom, $urandom, 31'($urandom), 31'($urandom));
      end
      2: begin
        // zero length in the xy plane, and sometimes in both
        it.x_in = 0;
        it.y_in = 0;
        if ($urandom_range(0, 1)) it.z_in = 0;
      end
      3: begin
        it.z_in = 0;
        if ($urandom_range(0, 1)) it.y_in = 0;
      end
      4: begin
        it.radius_in = $urandom_range(0, 1) ? 31'd0 : 31'h7FFFFFFF;
      end
      5: begin
        it.x_in = $urandom_range(0, 1) ? 32'sh80000000 : 32'sh7FFFFFFF;
        it.y_in = $urandom;
      end
      default: ;
    endcase
    return it;
  endfunction

  // waits for the request on the port to be taken
  task automatic issue(mb3_pkg::in_item_t it, bit allow_gap);
    int gap;
    if (allow_gap && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    add_row(mk(0, 0, 0, 0, 0), 1'b1, mko(0, 0, 0, 0, 1'b1, 1'b0));
    add_row(mk(ONE, 0, 0, ONE, ONE), 1'b1, mko(ONE, 0, 0, 31'h02000000, 1'b0, 1'b0));
    add_row(mk(0, 0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF), 1'b1,
            mko(0, 0, 0, 31'h7FFFFFFF, 1'b1, 1'b1));
    // radius zero clears the point but is not degenerate
    add_row(mk(ONE, ONE, ONE, 0, 31'h7FFFFFFF), 1'b1, mko(0, 0, 0, 0, 1'b0, 1'b0));
    add_row(mk(0, 0, ONE, ONE, ONE));
    add_row(mk(0, ONE, 0, ONE, ONE));
    add_row(mk(-ONE, 0, ONE, ONE, ONE));
    add_row(mk(-ONE, -ONE, -ONE, ONE, ONE));
    add_row(mk(32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h7FFFFFFF, 31'h7FFFFFFF));
    add_row(mk(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'h7FFFFFFF, 1));
    add_row(mk(32'sh80000000, 32'sh7FFFFFFF, 0, ONE, ONE));
    add_row(mk(32'sh7FFFFFFF, 0, 32'sh80000000, ONE, ONE));
    add_row(mk(1, -1, 1, 1, 1));
    add_row(mk(-1, 0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF));
    add_row(mk(ONE, -ONE, 32'sh02000000, 31'h02000000, 31'h00800000));
    add_row(mk(-32'sh00800000, 32'sh01800000, -32'sh03000000, 31'h01800000, ONE));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].known && bulb_step(dir_rows[i].stim) != dir_rows[i].want) begin
        $error("typed-in result for row %0d disagrees with prediction", i);
        n_errors++;
      end
      issue(dir_rows[i].stim, 1'b1);
    end

    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM / 2) begin
        // hold off until the pipeline has drained
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
      end
      issue(random_request(), k < N_RANDOM - CALM_TAIL);
    end
    start <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (mb3_pkg::TOTAL_LAT + 10) @(posedge clk);
    if (n_errors == 0 && pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### mandelbulb3_iteration_step_core.f
src/mb3_pkg.sv
src/mb3_plane.sv
src/mandelbulb3_iteration_step_core.sv
tb/sv/mandelbulb3_iteration_step_core_tb.sv
